### design/fsba_pkg.sv
// Package with shared types and constants for the fit strategy block allocator.
`timescale 1ns / 1ps
package fsba_pkg;

  localparam int unsigned MemUnitsDef     = 1024;
  localparam int unsigned TableEntriesDef = 64;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_REALLOC = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOSPACE  = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [1:0] STRAT_FIRST = 2'd0;
  localparam logic [1:0] STRAT_BEST  = 2'd1;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  owner;
    logic [10:0] length;
  } fsba_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  position;
    logic [10:0] prev_size;
    logic [9:0]  prev_position;
  } fsba_rsp_t;

  // Datapath commands issued by the controller.
  typedef struct packed {
    logic load;        // capture request
    logic clr_init;    // occupancy clearing step
    logic rec_rd;      // read record at rec index
    logic rec_next;    // advance record index
    logic scan_start;  // reset scan state
    logic scan_step;   // examine one map unit
    logic mark_step;   // write one map unit
    logic mark_set;    // value written by mark
    logic mark_from_rec; // marking uses freed record run
    logic rec_write;   // append a new record
    logic rec_release; // set released flag at hit index
  } fsba_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic rec_end;     // record index reached count
    logic rec_hit;     // record just read matches owner and is live
    logic scan_done;
    logic found;
    logic mark_done;
    logic table_full;
    logic len_bad;
  } fsba_sts_t;

endpackage

### design/fit_strategy_block_allocator_top.sv
// Top level of the fit strategy block allocator.
//
// Channel    Signals                       Direction  Transaction
// request    start, busy, req_i            in         start high while busy low
// result     done_o, rsp_o                 out        done_o high for one cycle
// config     strategy_we_i, strategy_i     in         strategy_we_i high
//
// After reset the occupancy map is cleared one unit at a time with busy high.
// A request searches the record table (a read state and a check state per record),
// unmarks the freed run, scans the map with its registered read, marks the new
// run and then presents the result, each step as its operation needs it.
// The result cannot be stalled.
`timescale 1ns / 1ps
module fit_strategy_block_allocator_top
  import fsba_pkg::*;
#(
  parameter int unsigned MemUnits     = MemUnitsDef,
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  fsba_req_t  req_i,
  output logic       done_o,
  output fsba_rsp_t  rsp_o,
  input  logic       strategy_we_i,
  input  logic [1:0] strategy_i
);

  fsba_cmd_t  cmd;
  fsba_sts_t  sts;
  logic [1:0] strategy_q;
  logic [1:0] status;
  logic       nv, fv, rl;
  logic [9:0] new_pos, old_pos;
  logic [10:0] freed_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) strategy_q <= STRAT_FIRST;
    else if (strategy_we_i) strategy_q <= strategy_i;
  end

  fsba_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .op_i(req_i.op), .sts_i(sts), .cmd_o(cmd),
    .busy_o(busy), .done_o, .status_o(status), .new_valid_o(nv),
    .free_valid_o(fv), .realloc_o(rl)
  );

  fsba_datapath #(.MemUnits(MemUnits), .TableEntries(TableEntries)) u_dp (
    .clk_i, .rst_ni, .strategy_i(strategy_q), .req_i, .cmd_i(cmd), .sts_o(sts),
    .new_pos_o(new_pos), .freed_len_o(freed_len), .old_pos_o(old_pos)
  );

  always_comb begin
    rsp_o.status        = status;
    rsp_o.prev_size     = freed_len;
    rsp_o.prev_position = rl ? old_pos : '0;
    if (nv) rsp_o.position = new_pos;
    else if (fv && !rl) rsp_o.position = old_pos;
    else rsp_o.position = '0;
  end

endmodule

### design/fsba_datapath.sv
// Datapath of the allocator: occupancy map, record table, scan and mark units.
`timescale 1ns / 1ps
module fsba_datapath
  import fsba_pkg::*;
#(
  parameter int unsigned MemUnits     = MemUnitsDef,
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic [1:0] strategy_i,
  input  fsba_req_t req_i,
  input  fsba_cmd_t cmd_i,
  output fsba_sts_t sts_o,
  output logic [9:0]  new_pos_o,
  output logic [10:0] freed_len_o,
  output logic [9:0]  old_pos_o
);

  localparam int unsigned AW = $clog2(MemUnits);
  localparam int unsigned RW = $clog2(TableEntries);
  localparam int unsigned UW = AW + 1;
  localparam int unsigned CW = RW + 1;

  logic                occ_q [MemUnits];
  logic [7:0]          own_q [TableEntries];
  logic [AW-1:0]       rstart_q [TableEntries];
  logic [10:0]         rsize_q [TableEntries];
  logic                rrel_q [TableEntries];

  fsba_req_t     req_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ridx_q;
  logic          occ_rd_q;
  logic [7:0]    rd_own_q;
  logic [AW-1:0] rd_start_q;
  logic [10:0]   rd_size_q;
  logic          rd_rel_q;
  logic [RW-1:0] hit_q;
  logic [AW-1:0] old_start_q;
  logic [10:0]   freed_len_q;
  logic [UW-1:0] ui_q;
  logic [UW-1:0] run_start_q;
  logic [UW-1:0] run_len_q;
  logic          have_q;
  logic [UW-1:0] best_q;
  logic [UW-1:0] best_len_q;
  logic [UW-1:0] mk_q;
  logic [10:0]   mk_left_q;
  logic          stop_q;
  logic          scan_vld_q;

  logic [UW-1:0] len_u;
  logic          fits, take, unit_free;
  logic [UW-1:0] run_len_n;
  logic [UW-1:0] eu;

  // The unit being examined is the one read in the previous cycle.
  assign eu = ui_q - 1'b1;
  assign len_u = UW'(req_q.length);
  assign unit_free = (eu < UW'(MemUnits)) && !occ_rd_q;
  assign run_len_n = run_len_q;
  assign fits = (run_len_n >= len_u) && (run_len_n != '0);
  always_comb begin
    priority if (strategy_i == STRAT_FIRST) take = !have_q;
    else if (strategy_i == STRAT_BEST) take = !have_q || (run_len_n < best_len_q);
    else take = !have_q || (run_len_n > best_len_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ridx_q  <= '0;
    end else begin
      count_q <= count_d;
      if (cmd_i.load || cmd_i.clr_init) ridx_q <= '0;
      else if (cmd_i.rec_next) ridx_q <= ridx_q + 1'b1;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.rec_write) count_d = count_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.rec_rd) begin
      rd_own_q   <= own_q[ridx_q[RW-1:0]];
      rd_start_q <= rstart_q[ridx_q[RW-1:0]];
      rd_size_q  <= rsize_q[ridx_q[RW-1:0]];
      rd_rel_q   <= rrel_q[ridx_q[RW-1:0]];
      hit_q      <= ridx_q[RW-1:0];
    end
    if (cmd_i.rec_release) begin
      rrel_q[hit_q] <= 1'b1;
      old_start_q   <= rd_start_q;
      freed_len_q   <= rd_size_q;
    end
    if (cmd_i.load) begin
      old_start_q <= '0;
      freed_len_q <= '0;
    end
    if (cmd_i.rec_write) begin
      own_q[count_q[RW-1:0]]    <= req_q.owner;
      rstart_q[count_q[RW-1:0]] <= best_q[AW-1:0];
      rsize_q[count_q[RW-1:0]]  <= req_q.length;
      rrel_q[count_q[RW-1:0]]   <= 1'b0;
    end
  end

  // Occupancy map: clearing sweep after reset, then unit-at-a-time marking,
  // with a registered read at the scan address.
  logic [UW-1:0] mk_addr;
  assign mk_addr = mk_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_init) occ_q[ui_q[AW-1:0]] <= 1'b0;
    else if (cmd_i.mark_step && mk_left_q != '0 && mk_addr < UW'(MemUnits))
      occ_q[mk_addr[AW-1:0]] <= cmd_i.mark_set;
    occ_rd_q <= occ_q[ui_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ui_q <= '0;
    end else if (cmd_i.clr_init) begin
      ui_q <= ui_q + 1'b1;
    end else if (cmd_i.scan_start) begin
      ui_q <= '0;
    end else if (cmd_i.scan_step) begin
      ui_q <= ui_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      run_start_q <= '0;
      run_len_q   <= '0;
      have_q      <= 1'b0;
      best_q      <= '0;
      best_len_q  <= '0;
      stop_q      <= 1'b0;
      scan_vld_q  <= 1'b0;
    end else if (cmd_i.scan_step && !stop_q) begin
      scan_vld_q <= 1'b1;
      if (scan_vld_q) begin
        if (unit_free) begin
          run_len_q <= run_len_q + 1'b1;
        end else begin
          if (fits && take) begin
            have_q     <= 1'b1;
            best_q     <= run_start_q;
            best_len_q <= run_len_n;
          end
          run_len_q   <= '0;
          run_start_q <= ui_q;
          stop_q      <= (fits && take && strategy_i == STRAT_FIRST)
                         || (eu >= UW'(MemUnits));
        end
      end
    end
    if (cmd_i.scan_start) begin
      mk_q      <= '0;
      mk_left_q <= '0;
    end else if (cmd_i.mark_step) begin
      if (mk_left_q != '0) begin
        mk_q      <= mk_q + 1'b1;
        mk_left_q <= mk_left_q - 1'b1;
      end
    end else if (cmd_i.mark_from_rec) begin
      mk_q      <= UW'(rd_start_q);
      mk_left_q <= rd_size_q;
    end else if (cmd_i.rec_write) begin
      mk_q      <= best_q;
      mk_left_q <= req_q.length;
    end
  end

  assign sts_o.clr_done   = (ui_q == UW'(MemUnits - 1));
  assign sts_o.rec_end    = (ridx_q >= count_q);
  assign sts_o.rec_hit    = (rd_own_q == req_q.owner) && !rd_rel_q;
  assign sts_o.scan_done  = stop_q;
  assign sts_o.found      = have_q;
  assign sts_o.mark_done  = (mk_left_q == '0);
  assign sts_o.table_full = (count_q >= CW'(TableEntries));
  assign sts_o.len_bad    = (req_q.length == '0) || (UW'(req_q.length) > UW'(MemUnits));

  assign new_pos_o   = 10'(best_q);
  assign freed_len_o = freed_len_q;
  assign old_pos_o   = 10'(old_start_q);

endmodule

### design/fsba_ctrl.sv
// Controller state machine sequencing the clearing sweep, record search, free, scan and mark phases.
`timescale 1ns / 1ps
module fsba_ctrl
  import fsba_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic [1:0] op_i,
  input  fsba_sts_t sts_i,
  output fsba_cmd_t cmd_o,
  output logic      busy_o,
  output logic      done_o,
  output logic [1:0] status_o,
  output logic      new_valid_o,
  output logic      free_valid_o,
  output logic      realloc_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RREAD, S_RCHK, S_FMARK, S_ACHK, S_SCAN, S_AMARK, S_DONE
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] op_q;
  logic [1:0] status_q, status_d;
  logic       nv_q, nv_d, fv_q, fv_d;

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    nv_d     = nv_q;
    fv_d     = fv_q;
    cmd_o    = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_init = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          status_d = ST_OK;
          nv_d = 1'b0;
          fv_d = 1'b0;
          priority if (op_i == OP_ALLOC) state_d = S_ACHK;
          else if (op_i == OP_FREE || op_i == OP_REALLOC) state_d = S_RREAD;
          else state_d = S_DONE;
        end
      end
      S_RREAD: begin
        if (sts_i.rec_end) begin
          status_d = ST_NOTFOUND;
          state_d = S_DONE;
        end else begin
          cmd_o.rec_rd = 1'b1;
          cmd_o.rec_next = 1'b1;
          state_d = S_RCHK;
        end
      end
      S_RCHK: begin
        if (sts_i.rec_hit) begin
          cmd_o.rec_release = 1'b1;
          cmd_o.mark_from_rec = 1'b1;
          fv_d = 1'b1;
          state_d = S_FMARK;
        end else begin
          state_d = S_RREAD;
        end
      end
      S_FMARK: begin
        cmd_o.mark_step = 1'b1;
        if (sts_i.mark_done) state_d = (op_q == OP_REALLOC) ? S_ACHK : S_DONE;
      end
      S_ACHK: begin
        cmd_o.scan_start = 1'b1;
        if (sts_i.table_full) begin
          status_d = ST_FULL;
          state_d = S_DONE;
        end else if (sts_i.len_bad) begin
          status_d = ST_NOSPACE;
          state_d = S_DONE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          if (sts_i.found) begin
            cmd_o.rec_write = 1'b1;
            nv_d = 1'b1;
            state_d = S_AMARK;
          end else begin
            status_d = ST_NOSPACE;
            state_d = S_DONE;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_AMARK: begin
        cmd_o.mark_step = 1'b1;
        cmd_o.mark_set = 1'b1;
        if (sts_i.mark_done) state_d = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      op_q     <= OP_ALLOC;
      status_q <= ST_OK;
      nv_q     <= 1'b0;
      fv_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      nv_q     <= nv_d;
      fv_q     <= fv_d;
      if (cmd_o.load) op_q <= op_i;
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = (state_q == S_DONE);
  assign status_o     = status_q;
  assign new_valid_o  = nv_q;
  assign free_valid_o = fv_q;
  assign realloc_o    = (op_q == OP_REALLOC);

endmodule

### tb/fit_strategy_block_allocator_top_test.sv
// Self-checking testbench for the fit strategy block allocator top level.
`timescale 1ns / 1ps
module fit_strategy_block_allocator_top_test;
  import fsba_pkg::*;

  localparam logic [1:0] OP_NOP      = 2'd3;
  localparam logic [1:0] STRAT_WORST = 2'd2;
  localparam logic [1:0] STRAT_ALIAS = 2'd3;
  localparam logic [7:0] OWNER_DOT   = 8'h2E;
  localparam int         UNITS       = MemUnitsDef;
  localparam int         RECORDS     = TableEntriesDef;
  localparam int         STALL_LIMIT = 20000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  fsba_req_t  req_i = '0;
  logic       done_o;
  fsba_rsp_t  rsp_o;
  logic       strategy_we_i = 1'b0;
  logic [1:0] strategy_i = '0;

  fit_strategy_block_allocator_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .done_o(done_o), .rsp_o(rsp_o), .strategy_we_i(strategy_we_i),
    .strategy_i(strategy_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Allocator state as the block should hold it.
  bit          unit_used [UNITS];
  logic [7:0]  rec_owner [RECORDS];
  int          rec_start [RECORDS];
  int          rec_size [RECORDS];
  bit          rec_freed [RECORDS];
  int          rec_count;
  logic [1:0]  fit_rule;

  fsba_rsp_t   pending_results[$];
  int          errors;
  int          quiet_cycles;
  bit          allow_gaps;

  function automatic bit locate_run(int size, output int pos);
    int i, run, best_len;
    bit have;
    i = 0; best_len = 0; have = 0; pos = 0;
    if (size == 0 || size > UNITS) return 0;
    while (i + size <= UNITS) begin
      run = 0;
      while (i + run < UNITS && !unit_used[i + run]) run++;
      if (run >= size) begin
        if (!have || (fit_rule == STRAT_BEST && run < best_len) ||
            (fit_rule != STRAT_FIRST && fit_rule != STRAT_BEST && run > best_len)) begin
          have = 1; pos = i; best_len = run;
        end
        if (fit_rule == STRAT_FIRST) break;
      end
      i += (run != 0) ? run : 1;
    end
    return have;
  endfunction

  function automatic void fill_units(int from, int size, bit v);
    for (int k = 0; k < size; k++)
      if (from + k < UNITS) unit_used[from + k] = v;
  endfunction

  function automatic logic [1:0] place_run(logic [7:0] owner, int size, output int pos);
    int p;
    pos = 0;
    if (rec_count >= RECORDS) return ST_FULL;
    if (!locate_run(size, p)) return ST_NOSPACE;
    fill_units(p, size, 1'b1);
    rec_owner[rec_count] = owner;
    rec_start[rec_count] = p;
    rec_size[rec_count] = size;
    rec_freed[rec_count] = 1'b0;
    rec_count++;
    pos = p;
    return ST_OK;
  endfunction

  function automatic bit release_owner(logic [7:0] owner, output int from, output int size);
    from = 0; size = 0;
    for (int r = 0; r < rec_count; r++) begin
      if (rec_owner[r] == owner && !rec_freed[r]) begin
        fill_units(rec_start[r], rec_size[r], 1'b0);
        rec_freed[r] = 1'b1;
        from = rec_start[r];
        size = rec_size[r];
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic fsba_rsp_t allocator_outcome(fsba_req_t rq);
    fsba_rsp_t r;
    int pos, from, size;
    r = '0;
    pos = 0;
    case (rq.op)
      OP_ALLOC: begin
        r.status = place_run(rq.owner, int'(rq.length), pos);
        r.position = pos[9:0];
      end
      OP_FREE: begin
        if (release_owner(rq.owner, from, size)) begin
          r.position = from[9:0];
          r.prev_size = size[10:0];
        end else begin
          r.status = ST_NOTFOUND;
        end
      end
      OP_REALLOC: begin
        if (release_owner(rq.owner, from, size)) begin
          r.prev_position = from[9:0];
          r.prev_size = size[10:0];
          r.status = place_run(rq.owner, int'(rq.length), pos);
          r.position = pos[9:0];
        end else begin
          r.status = ST_NOTFOUND;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, rsp_o);
          errors++;
        end else begin
          fsba_rsp_t want;
          want = pending_results.pop_front();
          if (rsp_o.status !== want.status || rsp_o.position !== want.position ||
              rsp_o.prev_size !== want.prev_size ||
              rsp_o.prev_position !== want.prev_position) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, want, rsp_o);
            errors++;
          end
        end
      end
    end
  end

  task automatic idle_gap();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) begin
      @(negedge clk_i);
      start = 1'b0;
    end
  endtask

  task automatic issue(logic [1:0] op, logic [7:0] owner, logic [10:0] length);
    if (allow_gaps && $urandom_range(0, 3) == 0) idle_gap();
    @(negedge clk_i);
    start = 1'b1;
    req_i = '{op: op, owner: owner, length: length};
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    pending_results.push_back(allocator_outcome(req_i));
  endtask

  task automatic set_rule(logic [1:0] rule);
    @(negedge clk_i);
    start = 1'b0;
    while (pending_results.size() != 0 || busy) @(negedge clk_i);
    strategy_we_i = 1'b1;
    strategy_i = rule;
    @(negedge clk_i);
    strategy_we_i = 1'b0;
    fit_rule = rule;
  endtask

  task automatic test_corner_requests();
    issue(OP_NOP, 8'hFF, 11'h7FF);
    issue(OP_ALLOC, 8'h00, 11'd0);
    issue(OP_ALLOC, 8'h01, 11'd1025);
    issue(OP_ALLOC, 8'hFF, 11'h7FF);
    issue(OP_FREE, OWNER_DOT, 11'd5);
    issue(OP_REALLOC, OWNER_DOT, 11'd5);
  endtask

  task automatic test_fit_rules();
    issue(OP_ALLOC, 8'h00, 11'd100);
    issue(OP_ALLOC, 8'h01, 11'd50);
    issue(OP_ALLOC, 8'h02, 11'd200);
    issue(OP_ALLOC, 8'h03, 11'd30);
    issue(OP_ALLOC, OWNER_DOT, 11'd1);
    issue(OP_FREE, 8'h01, 11'd0);
    issue(OP_FREE, 8'h03, 11'd0);
    set_rule(STRAT_BEST);
    issue(OP_ALLOC, 8'h04, 11'd20);
    set_rule(STRAT_WORST);
    issue(OP_ALLOC, 8'h05, 11'd20);
    set_rule(STRAT_ALIAS);
    issue(OP_ALLOC, 8'h06, 11'd10);
    issue(OP_REALLOC, 8'h00, 11'd1024);
    issue(OP_REALLOC, OWNER_DOT, 11'd40);
    issue(OP_ALLOC, 8'hFF, 11'd1024);
  endtask

  task automatic test_random_traffic();
    logic [1:0]  op;
    logic [7:0]  owner;
    logic [10:0] length;
    int          pick;
    for (int n = 0; n < 560; n++) begin
      if (n % 40 == 0 && n != 0) set_rule(2'($urandom_range(0, 3)));
      allow_gaps = (n < 460);
      pick = $urandom_range(0, 99);
      op = (pick < 45) ? OP_ALLOC : (pick < 70) ? OP_FREE : (pick < 90) ? OP_REALLOC : OP_NOP;
      owner = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0) owner = OWNER_DOT;
      length = ($urandom_range(0, 5) == 0) ? 11'($urandom) : 11'($urandom_range(1, 64));
      issue(op, owner, length);
    end
  endtask

  initial begin
    int waited;
    errors = 0;
    quiet_cycles = 0;
    rec_count = 0;
    fit_rule = STRAT_FIRST;
    allow_gaps = 1'b1;
    foreach (unit_used[k]) unit_used[k] = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_corner_requests();
    test_fit_rules();
    set_rule(STRAT_FIRST);
    test_random_traffic();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    waited = 0;
    while (waited < 100) begin
      @(posedge clk_i);
      waited++;
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### fit_strategy_block_allocator_top.f
design/fsba_pkg.sv
design/fsba_datapath.sv
design/fsba_ctrl.sv
design/fit_strategy_block_allocator_top.sv
tb/fit_strategy_block_allocator_top_test.sv
